>>> hw/rtl/twis_pkg.sv
// Shared command and status types for the trie word insert and search core.
package twis_pkg;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic link;
    logic mark;
    logic report;
    logic clear;
  } twis_cmd_t;

  typedef struct packed {
    logic walk_ok;
    logic last;
    logic is_search;
    logic clear_done;
  } twis_status_t;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

endpackage

>>> hw/rtl/twis_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module twis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/twis_ctrl.sv
// Controller state machine that sequences capture, lookup, link, mark, report and clearing steps.
module twis_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_has_letter,
  input  logic                  in_last,
  input  twis_pkg::twis_status_t status,
  output twis_pkg::twis_cmd_t   cmd,
  output logic                  busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_LINK,
    S_MARK,
    S_REPORT,
    S_CLEAR
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (in_has_letter) begin
            state_nxt = S_LOOKUP;
          end else if (in_last) begin
            state_nxt = S_MARK;
          end
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (status.walk_ok) begin
          state_nxt = S_LINK;
        end else if (status.last) begin
          state_nxt = S_MARK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = status.last ? S_MARK : S_IDLE;
      end
      S_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = status.is_search ? S_REPORT : S_IDLE;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

>>> hw/rtl/twis_datapath.sv
// Datapath holding the cursor, node allocator, word flags, clear counter and trie memories.
module twis_datapath #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  twis_pkg::twis_cmd_t    cmd,
  input  logic                   in_kind,
  input  logic [4:0]             in_letter,
  input  logic                   in_last,
  output twis_pkg::twis_status_t status,
  output logic                   out_valid,
  output logic                   out_op_kind,
  output logic                   out_found,
  output logic                   out_overflow
);

  localparam int TABLE_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int NW          = $clog2(NODE_COUNT);
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam logic [NW:0]   POOL_LIMIT = (NW + 1)'(NODE_COUNT);
  localparam logic [8:0]    ALPHA_LIMIT = 9'(ALPHABET_SIZE);
  localparam logic [AW-1:0] CLEAR_LAST = AW'(TABLE_DEPTH - 1);
  localparam logic [AW-1:0] MARK_LIMIT = AW'(NODE_COUNT);

  logic          kind_r;
  logic [4:0]    letter_r;
  logic          last_r;
  logic [NW-1:0] cursor_r;
  logic [NW-1:0] cursor_nxt;
  logic [NW:0]   used_r;
  logic [NW:0]   used_nxt;
  logic          missed_r;
  logic          missed_nxt;
  logic          ovf_r;
  logic          ovf_nxt;
  logic [AW-1:0] slot_r;
  logic [AW-1:0] slot;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] clr_cnt_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic          out_op_kind_r;
  logic          out_op_kind_nxt;
  logic          out_found_r;
  logic          out_found_nxt;
  logic          out_overflow_r;
  logic          out_overflow_nxt;

  logic          skipped;
  logic          bad_letter;
  logic          walk_ok;

  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  logic [NW-1:0] tbl_wdata;
  logic          tbl_re;
  logic [NW-1:0] tbl_rdata;

  logic          mark_we;
  logic [NW-1:0] mark_waddr;
  logic [0:0]    mark_wdata;
  logic          mark_re;
  logic [0:0]    mark_rdata;

  assign skipped    = (kind_r == twis_pkg::KIND_SEARCH) ? missed_r : ovf_r;
  assign bad_letter = ({4'd0, letter_r} >= ALPHA_LIMIT);
  assign walk_ok    = !skipped && !bad_letter;
  assign slot       = AW'(cursor_r) * AW'(ALPHABET_SIZE) + AW'(letter_r);

  always_comb begin
    cursor_nxt       = cursor_r;
    used_nxt         = used_r;
    missed_nxt       = missed_r;
    ovf_nxt          = ovf_r;
    clr_cnt_nxt      = clr_cnt_r;
    out_valid_nxt    = 1'b0;
    out_op_kind_nxt  = out_op_kind_r;
    out_found_nxt    = out_found_r;
    out_overflow_nxt = out_overflow_r;
    tbl_we           = 1'b0;
    tbl_waddr        = slot_r;
    tbl_wdata        = used_r[NW-1:0];
    tbl_re           = 1'b0;
    mark_we          = 1'b0;
    mark_waddr       = cursor_r;
    mark_wdata       = 1'b1;
    mark_re          = 1'b0;

    if (cmd.lookup) begin
      if (walk_ok) begin
        tbl_re = 1'b1;
      end else if (!skipped) begin
        if (kind_r == twis_pkg::KIND_SEARCH) begin
          missed_nxt = 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end

    if (cmd.link) begin
      if (tbl_rdata != '0) begin
        cursor_nxt = tbl_rdata;
      end else if (kind_r == twis_pkg::KIND_SEARCH) begin
        missed_nxt = 1'b1;
      end else if (used_r >= POOL_LIMIT) begin
        ovf_nxt = 1'b1;
      end else begin
        tbl_we     = 1'b1;
        cursor_nxt = used_r[NW-1:0];
        used_nxt   = used_r + 1'b1;
      end
    end

    if (cmd.mark) begin
      if (kind_r == twis_pkg::KIND_SEARCH) begin
        mark_re = 1'b1;
      end else begin
        mark_we          = !ovf_r;
        out_valid_nxt    = 1'b1;
        out_op_kind_nxt  = twis_pkg::KIND_INSERT;
        out_found_nxt    = 1'b0;
        out_overflow_nxt = ovf_r;
        cursor_nxt       = '0;
        missed_nxt       = 1'b0;
        ovf_nxt          = 1'b0;
      end
    end

    if (cmd.report) begin
      out_valid_nxt    = 1'b1;
      out_op_kind_nxt  = twis_pkg::KIND_SEARCH;
      out_found_nxt    = !missed_r && mark_rdata[0];
      out_overflow_nxt = 1'b0;
      cursor_nxt       = '0;
      missed_nxt       = 1'b0;
      ovf_nxt          = 1'b0;
    end

    if (cmd.clear) begin
      tbl_we      = 1'b1;
      tbl_waddr   = clr_cnt_r;
      tbl_wdata   = '0;
      mark_we     = (clr_cnt_r < MARK_LIMIT);
      mark_waddr  = clr_cnt_r[NW-1:0];
      mark_wdata  = 1'b0;
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      used_r      <= (NW + 1)'(1);
      missed_r    <= 1'b0;
      ovf_r       <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r    <= cursor_nxt;
      used_r      <= used_nxt;
      missed_r    <= missed_nxt;
      ovf_r       <= ovf_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= in_kind;
      letter_r <= in_letter;
      last_r   <= in_last;
    end
    if (cmd.lookup) begin
      slot_r <= slot;
    end
    out_op_kind_r  <= out_op_kind_nxt;
    out_found_r    <= out_found_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  twis_ram #(
    .WIDTH (NW),
    .DEPTH (TABLE_DEPTH)
  ) u_child_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (slot),
    .rdata (tbl_rdata)
  );

  twis_ram #(
    .WIDTH (1),
    .DEPTH (NODE_COUNT)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (mark_re),
    .raddr (cursor_r),
    .rdata (mark_rdata)
  );

  assign status.walk_ok    = walk_ok;
  assign status.last       = last_r;
  assign status.is_search  = (kind_r == twis_pkg::KIND_SEARCH);
  assign status.clear_done = (clr_cnt_r == CLEAR_LAST);

  assign out_valid    = out_valid_r;
  assign out_op_kind  = out_op_kind_r;
  assign out_found    = out_found_r;
  assign out_overflow = out_overflow_r;

endmodule

>>> hw/rtl/trie_word_insert_search_core.sv
// Top level of the trie word insert and search core: controller, datapath and checks.
//
//   Channel   Handshake              Ports
//   input     start high, busy low   in_kind, in_letter, in_has_letter, in_last
//   result    out_valid, one cycle   out_op_kind, out_found, out_overflow
//
// An item without a letter that is not the last one is only captured. An item with a letter
// is captured, looked up in the child table (a registered read) and linked, which moves the
// cursor; the link is skipped if its word has already failed or the letter is out of range.
// A final item adds the word-end mark access: a mark write for an insert, a mark read and a
// report for a search. After reset a clearing pass writes all NODE_COUNT * ALPHABET_SIZE
// child-table entries (26624 by default), with busy high. The receiver cannot stall results.
module trie_word_insert_search_core #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_kind,
  input  logic [4:0] in_letter,
  input  logic       in_has_letter,
  input  logic       in_last,
  output logic       out_valid,
  output logic       out_op_kind,
  output logic       out_found,
  output logic       out_overflow
);

  twis_pkg::twis_cmd_t    cmd;
  twis_pkg::twis_status_t status;

  twis_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_has_letter (in_has_letter),
    .in_last       (in_last),
    .status        (status),
    .cmd           (cmd),
    .busy          (busy)
  );

  twis_datapath #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_kind      (in_kind),
    .in_letter    (in_letter),
    .in_last      (in_last),
    .status       (status),
    .out_valid    (out_valid),
    .out_op_kind  (out_op_kind),
    .out_found    (out_found),
    .out_overflow (out_overflow)
  );

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.lookup, cmd.link, cmd.mark, cmd.report, cmd.clear}))
    else $error("More than one controller step issued in one cycle.");

  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result transaction issued while the core is still busy.");

  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Two result transactions in consecutive cycles.");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && !out_op_kind) && !(out_overflow && out_op_kind))
    else $error("Result flag does not match the operation kind.");

endmodule
